// ===== rtl/core/eip5t_pkg.sv =====
// eip5t_pkg: constants of the ethernet / 802.1Q / ipv4 / tcp-udp header parser
// used by ethernet_ipv4_five_tuple_parser_core; depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package eip5t_pkg;

  // ethertypes and ip protocol numbers
  localparam logic [15:0] TYPE_VLAN = 16'h8100;
  localparam logic [15:0] TYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_TCP = 8'd6;
  localparam logic [7:0]  PROTO_UDP = 8'd17;

  // header geometry in bytes
  localparam int unsigned ETH_LEN    = 14;
  localparam int unsigned TAG_LEN    = 4;
  localparam int unsigned IP_MIN_LEN = 20;
  localparam int unsigned TYPE_HI    = 12;   // outer ethertype bytes
  localparam int unsigned TYPE_LO    = 13;
  localparam int unsigned ITYPE_HI   = 16;   // ethertype behind the tag
  localparam int unsigned ITYPE_LO   = 17;

  // byte positions inside the ip header
  localparam int unsigned IP_VER_IHL = 0;
  localparam int unsigned IP_LEN_HI  = 2;
  localparam int unsigned IP_LEN_LO  = 3;
  localparam int unsigned IP_PROTO   = 9;
  localparam int unsigned IP_SRC     = 12;
  localparam int unsigned IP_DST     = 16;

  // byte positions inside the transport header
  localparam int unsigned TR_PORT_END = 4;
  localparam int unsigned TR_SEQ_END  = 12;
  localparam int unsigned TR_FLAGS    = 13;

  // one result transaction
  typedef struct packed {
    logic        accepted;
    logic [7:0]  protocol;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [15:0] ip_total_length;
    logic [3:0]  tcp_flag_bits;
    logic [31:0] tcp_sequence;
    logic [31:0] tcp_acknowledge;
    logic [63:0] packets_seen;
    logic [63:0] bytes_total;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/ethernet_ipv4_five_tuple_parser_core.sv =====
// ethernet_ipv4_five_tuple_parser_core: byte-serial ethernet / vlan / ipv4 / tcp-udp parser
// depends on eip5t_pkg
//
//  channel | direction | ports                                   | moves
//  --------+-----------+-----------------------------------------+---------------------------
//  in_     | input     | in_valid, in_ready, in_data_byte,       | one frame byte per
//          |           | in_last_byte                            | transaction
//  out_    | output    | out_valid, out_ready, out_accepted ...  | one parse result per frame
//          |           | out_bytes_total                         | (on the last byte)
//
// one byte per clock sustained, unless a last byte waits on a held result: an input register
// feeds the capture logic, which updates the per-frame state and, on the last byte, loads
// the result register
// rst_n is synchronous, active low; it clears valid flags, frame state and both totals
// a stalled out_ready only holds back a last byte; non-last bytes keep flowing while a
// result waits, since they produce no result
`timescale 1ns / 1ps
`default_nettype none

module ethernet_ipv4_five_tuple_parser_core
  import eip5t_pkg::*;
#(
  parameter int OFFSET_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_last_byte,

  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_accepted,
  output logic [7:0]       out_protocol,
  output logic [31:0]      out_src_addr,
  output logic [31:0]      out_dst_addr,
  output logic [15:0]      out_source_port,
  output logic [15:0]      out_dest_port,
  output logic [15:0]      out_ip_total_length,
  output logic [3:0]       out_tcp_flag_bits,
  output logic [31:0]      out_tcp_sequence,
  output logic [31:0]      out_tcp_acknowledge,
  output logic [63:0]      out_packets_seen,
  output logic [63:0]      out_bytes_total
);

  localparam int OB = OFFSET_BITS;

  // byte offsets at offset width
  localparam logic [OB-1:0] OFF_TYPE_HI  = OB'(TYPE_HI);
  localparam logic [OB-1:0] OFF_TYPE_LO  = OB'(TYPE_LO);
  localparam logic [OB-1:0] OFF_ITYPE_HI = OB'(ITYPE_HI);
  localparam logic [OB-1:0] OFF_ITYPE_LO = OB'(ITYPE_LO);
  localparam logic [OB-1:0] OFF_ETH      = OB'(ETH_LEN);
  localparam logic [OB-1:0] OFF_VLAN_IP  = OB'(ETH_LEN + TAG_LEN);
  localparam logic [OB-1:0] OFF_MIN_ETH  = OB'(ETH_LEN + IP_MIN_LEN - 1);
  localparam logic [OB-1:0] OFF_MIN_VLAN = OB'(ETH_LEN + TAG_LEN + IP_MIN_LEN - 1);
  localparam logic [OB-1:0] OFF_VER_IHL  = OB'(IP_VER_IHL);
  localparam logic [OB-1:0] OFF_LEN_HI   = OB'(IP_LEN_HI);
  localparam logic [OB-1:0] OFF_LEN_LO   = OB'(IP_LEN_LO);
  localparam logic [OB-1:0] OFF_PROTO    = OB'(IP_PROTO);
  localparam logic [OB-1:0] OFF_SRC      = OB'(IP_SRC);
  localparam logic [OB-1:0] OFF_DST      = OB'(IP_DST);
  localparam logic [OB-1:0] OFF_IP_END   = OB'(IP_MIN_LEN);
  localparam logic [OB-1:0] OFF_PORT_END = OB'(TR_PORT_END);
  localparam logic [OB-1:0] OFF_SEQ_END  = OB'(TR_SEQ_END);
  localparam logic [OB-1:0] OFF_FLAGS    = OB'(TR_FLAGS);

  // input register
  logic          s1_vld_r, s1_vld_nxt;
  logic [7:0]    s1_data_r;
  logic          s1_last_r;

  // per-frame capture state
  logic [OB-1:0] byte_offset_r, byte_offset_nxt;
  logic [15:0]   outer_type_r, outer_type_nxt;
  logic [15:0]   inner_type_r, inner_type_nxt;
  logic [3:0]    header_words_r, header_words_nxt;
  logic [15:0]   length_field_r, length_field_nxt;
  logic [7:0]    proto_field_r, proto_field_nxt;
  logic [31:0]   source_address_r, source_address_nxt;
  logic [31:0]   dest_address_r, dest_address_nxt;
  logic [31:0]   port_pair_r, port_pair_nxt;
  logic [63:0]   seq_ack_pair_r, seq_ack_pair_nxt;
  logic [3:0]    flag_capture_r, flag_capture_nxt;

  // running totals
  logic [63:0]   frame_counter_r, frame_counter_nxt;
  logic [63:0]   length_sum_r, length_sum_nxt;

  // result register
  logic          out_valid_r, out_valid_nxt;
  result_t       result_r, result_nxt;

  // handshake
  logic          in_acc;
  logic          s2_go;
  logic          s2_emit;

  // capture datapath
  logic          cur_vlan;
  logic [OB-1:0] ip_base;
  logic [OB-1:0] ip_pos;
  logic [3:0]    ihl;
  logic [OB-1:0] tr_start;
  logic [OB-1:0] tr_pos;

  // result datapath
  logic          end_vlan;
  logic [15:0]   end_type;
  logic [OB-1:0] end_min;
  logic          acc;
  logic          is_tcp;
  logic          is_udp;

  // a last byte may only move on when the result slot is free or being emptied
  assign s2_go    = s1_vld_r && (!s1_last_r || !out_valid_r || out_ready);
  assign s2_emit  = s2_go && s1_last_r;
  assign in_ready = !s1_vld_r || s2_go;
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    s1_vld_nxt = s1_vld_r;
    if (in_acc) begin
      s1_vld_nxt = 1'b1;
    end else if (s2_go) begin
      s1_vld_nxt = 1'b0;
    end
  end

  // per-byte capture; mirrors the header walk one byte at a time
  always_comb begin
    outer_type_nxt     = outer_type_r;
    inner_type_nxt     = inner_type_r;
    header_words_nxt   = header_words_r;
    length_field_nxt   = length_field_r;
    proto_field_nxt    = proto_field_r;
    source_address_nxt = source_address_r;
    dest_address_nxt   = dest_address_r;
    port_pair_nxt      = port_pair_r;
    seq_ack_pair_nxt   = seq_ack_pair_r;
    flag_capture_nxt   = flag_capture_r;

    cur_vlan = (outer_type_r == TYPE_VLAN);
    ip_base  = cur_vlan ? OFF_VLAN_IP : OFF_ETH;
    ip_pos   = byte_offset_r - ip_base;
    ihl      = (ip_pos == OFF_VER_IHL) ? s1_data_r[3:0] : header_words_r;
    tr_start = ip_base + OB'({ihl, 2'b00});
    tr_pos   = byte_offset_r - tr_start;

    if (byte_offset_r == OFF_TYPE_HI || byte_offset_r == OFF_TYPE_LO) begin
      outer_type_nxt = {outer_type_r[7:0], s1_data_r};
    end else if (byte_offset_r >= OFF_ETH) begin
      if (cur_vlan && (byte_offset_r == OFF_ITYPE_HI || byte_offset_r == OFF_ITYPE_LO)) begin
        inner_type_nxt = {inner_type_r[7:0], s1_data_r};
      end
      if (byte_offset_r >= ip_base) begin
        // ip header fields
        if (ip_pos == OFF_VER_IHL) begin
          header_words_nxt = s1_data_r[3:0];
        end else if (ip_pos == OFF_LEN_HI || ip_pos == OFF_LEN_LO) begin
          length_field_nxt = {length_field_r[7:0], s1_data_r};
        end else if (ip_pos == OFF_PROTO) begin
          proto_field_nxt = s1_data_r;
        end else if (ip_pos >= OFF_SRC && ip_pos < OFF_DST) begin
          source_address_nxt = {source_address_r[23:0], s1_data_r};
        end else if (ip_pos >= OFF_DST && ip_pos < OFF_IP_END) begin
          dest_address_nxt = {dest_address_r[23:0], s1_data_r};
        end
        // transport fields; may overlap the ip header when ihl is short
        if (byte_offset_r >= tr_start) begin
          if (tr_pos < OFF_PORT_END) begin
            port_pair_nxt = {port_pair_r[23:0], s1_data_r};
          end else if (tr_pos < OFF_SEQ_END) begin
            seq_ack_pair_nxt = {seq_ack_pair_r[55:0], s1_data_r};
          end else if (tr_pos == OFF_FLAGS) begin
            flag_capture_nxt = {s1_data_r[4], s1_data_r[2:0]};
          end
        end
      end
    end
  end

  // saturating byte index
  always_comb begin
    byte_offset_nxt = byte_offset_r;
    if (byte_offset_r != {OB{1'b1}}) begin
      byte_offset_nxt = byte_offset_r + OB'(1);
    end
  end

  // result built from the state as it stands after this byte
  always_comb begin
    end_vlan = (outer_type_nxt == TYPE_VLAN);
    end_type = end_vlan ? inner_type_nxt : outer_type_nxt;
    end_min  = end_vlan ? OFF_MIN_VLAN : OFF_MIN_ETH;
    acc      = (end_type == TYPE_IPV4) && (byte_offset_r >= end_min);
    is_tcp   = acc && (proto_field_nxt == PROTO_TCP);
    is_udp   = acc && (proto_field_nxt == PROTO_UDP);

    frame_counter_nxt = frame_counter_r + 64'd1;
    length_sum_nxt    = length_sum_r + (acc ? {48'd0, length_field_nxt} : 64'd0);

    result_nxt                 = '0;
    result_nxt.accepted        = acc;
    result_nxt.packets_seen    = frame_counter_nxt;
    result_nxt.bytes_total     = length_sum_nxt;
    if (acc) begin
      result_nxt.protocol        = proto_field_nxt;
      result_nxt.src_addr        = source_address_nxt;
      result_nxt.dst_addr        = dest_address_nxt;
      result_nxt.ip_total_length = length_field_nxt;
    end
    if (is_tcp || is_udp) begin
      result_nxt.source_port = port_pair_nxt[31:16];
      result_nxt.dest_port   = port_pair_nxt[15:0];
    end
    if (is_tcp) begin
      result_nxt.tcp_flag_bits   = flag_capture_nxt;
      result_nxt.tcp_sequence    = seq_ack_pair_nxt[63:32];
      result_nxt.tcp_acknowledge = seq_ack_pair_nxt[31:0];
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s2_emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
    end
    if (in_acc) begin
      s1_data_r <= in_data_byte;
      s1_last_r <= in_last_byte;
    end
  end

  // frame state: cleared after every last byte
  always_ff @(posedge clk) begin
    if (!rst_n || s2_emit) begin
      byte_offset_r    <= '0;
      outer_type_r     <= '0;
      inner_type_r     <= '0;
      header_words_r   <= '0;
      length_field_r   <= '0;
      proto_field_r    <= '0;
      source_address_r <= '0;
      dest_address_r   <= '0;
      port_pair_r      <= '0;
      seq_ack_pair_r   <= '0;
      flag_capture_r   <= '0;
    end else if (s2_go) begin
      byte_offset_r    <= byte_offset_nxt;
      outer_type_r     <= outer_type_nxt;
      inner_type_r     <= inner_type_nxt;
      header_words_r   <= header_words_nxt;
      length_field_r   <= length_field_nxt;
      proto_field_r    <= proto_field_nxt;
      source_address_r <= source_address_nxt;
      dest_address_r   <= dest_address_nxt;
      port_pair_r      <= port_pair_nxt;
      seq_ack_pair_r   <= seq_ack_pair_nxt;
      flag_capture_r   <= flag_capture_nxt;
    end
  end

  // running totals and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_counter_r <= '0;
      length_sum_r    <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (s2_emit) begin
        frame_counter_r <= frame_counter_nxt;
        length_sum_r    <= length_sum_nxt;
      end
    end
    if (s2_emit) begin
      result_r <= result_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_accepted        = result_r.accepted;
  assign out_protocol        = result_r.protocol;
  assign out_src_addr        = result_r.src_addr;
  assign out_dst_addr        = result_r.dst_addr;
  assign out_source_port     = result_r.source_port;
  assign out_dest_port       = result_r.dest_port;
  assign out_ip_total_length = result_r.ip_total_length;
  assign out_tcp_flag_bits   = result_r.tcp_flag_bits;
  assign out_tcp_sequence    = result_r.tcp_sequence;
  assign out_tcp_acknowledge = result_r.tcp_acknowledge;
  assign out_packets_seen    = result_r.packets_seen;
  assign out_bytes_total     = result_r.bytes_total;

endmodule

`default_nettype wire

// ===== sim/ethernet_ipv4_five_tuple_parser_core_tb.sv =====
// testbench for ethernet_ipv4_five_tuple_parser_core: directed and random frames byte by byte,
// with a built-in header parser model predicting every result transaction
// depends on eip5t_pkg and the rtl of ethernet_ipv4_five_tuple_parser_core
`timescale 1ns / 1ps

module ethernet_ipv4_five_tuple_parser_core_tb;
  import eip5t_pkg::*;

  localparam int QUIET_LIMIT = 4000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_last_byte = 1'b0;
  logic        out_ready = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic        out_accepted;
  logic [7:0]  out_protocol;
  logic [31:0] out_src_addr;
  logic [31:0] out_dst_addr;
  logic [15:0] out_source_port;
  logic [15:0] out_dest_port;
  logic [15:0] out_ip_total_length;
  logic [3:0]  out_tcp_flag_bits;
  logic [31:0] out_tcp_sequence;
  logic [31:0] out_tcp_acknowledge;
  logic [63:0] out_packets_seen;
  logic [63:0] out_bytes_total;

  ethernet_ipv4_five_tuple_parser_core uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data_byte(in_data_byte),
    .in_last_byte(in_last_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_accepted(out_accepted),
    .out_protocol(out_protocol),
    .out_src_addr(out_src_addr),
    .out_dst_addr(out_dst_addr),
    .out_source_port(out_source_port),
    .out_dest_port(out_dest_port),
    .out_ip_total_length(out_ip_total_length),
    .out_tcp_flag_bits(out_tcp_flag_bits),
    .out_tcp_sequence(out_tcp_sequence),
    .out_tcp_acknowledge(out_tcp_acknowledge),
    .out_packets_seen(out_packets_seen),
    .out_bytes_total(out_bytes_total)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // parser model state, one copy per frame plus the two running totals
  logic [15:0] byte_pos = '0;
  logic [15:0] outer_etype = '0;
  logic [15:0] inner_etype = '0;
  logic [3:0]  ihl_seen = '0;
  logic [15:0] total_len_seen = '0;
  logic [7:0]  proto_seen = '0;
  logic [31:0] src_seen = '0;
  logic [31:0] dst_seen = '0;
  logic [31:0] ports_seen = '0;
  logic [63:0] seq_ack_seen = '0;
  logic [3:0]  flags_seen = '0;
  logic [63:0] frame_count = '0;
  logic [63:0] length_total = '0;

  result_t     expected_results[$];
  logic [7:0]  frame_buf[$];
  int          mismatch_count = 0;
  bit          idle_on = 1'b0;
  int          stall_left = 0;
  int          quiet_cycles = 0;

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // advance the parser model by one accepted byte
  task automatic parse_byte(input logic [7:0] b, input logic last);
    int unsigned i;
    int unsigned ip0;
    int unsigned p;
    int unsigned t;
    int unsigned r;
    logic [15:0] etype;
    bit          acc;
    bit          tcp;
    bit          udp;
    result_t     res;
    i = 32'(byte_pos);
    if (i == TYPE_HI || i == TYPE_LO) begin
      outer_etype = {outer_etype[7:0], b};
    end else if (i >= ETH_LEN) begin
      ip0 = (outer_etype == TYPE_VLAN) ? ETH_LEN + TAG_LEN : ETH_LEN;
      if (outer_etype == TYPE_VLAN && (i == ITYPE_HI || i == ITYPE_LO)) begin
        inner_etype = {inner_etype[7:0], b};
      end
      if (i >= ip0) begin
        p = i - ip0;
        if (p == IP_VER_IHL) ihl_seen = b[3:0];
        else if (p == IP_LEN_HI || p == IP_LEN_LO) total_len_seen = {total_len_seen[7:0], b};
        else if (p == IP_PROTO) proto_seen = b;
        else if (p >= IP_SRC && p < IP_DST) src_seen = {src_seen[23:0], b};
        else if (p >= IP_DST && p < IP_MIN_LEN) dst_seen = {dst_seen[23:0], b};
        // transport bytes may overlap the ip header when ihl is below five
        t = ip0 + 4 * 32'(ihl_seen);
        if (i >= t) begin
          r = i - t;
          if (r < TR_PORT_END) ports_seen = {ports_seen[23:0], b};
          else if (r < TR_SEQ_END) seq_ack_seen = {seq_ack_seen[55:0], b};
          else if (r == TR_FLAGS) flags_seen = {b[4], b[2:0]};
        end
      end
    end
    if (byte_pos != '1) byte_pos = byte_pos + 16'd1;
    if (last) begin
      ip0 = (outer_etype == TYPE_VLAN) ? ETH_LEN + TAG_LEN : ETH_LEN;
      etype = (outer_etype == TYPE_VLAN) ? inner_etype : outer_etype;
      acc = (etype == TYPE_IPV4) && (i + 1 >= ip0 + IP_MIN_LEN);
      tcp = acc && proto_seen == PROTO_TCP;
      udp = acc && proto_seen == PROTO_UDP;
      res = '0;
      frame_count = frame_count + 64'd1;
      if (acc) begin
        res.accepted = 1'b1;
        res.protocol = proto_seen;
        res.src_addr = src_seen;
        res.dst_addr = dst_seen;
        res.ip_total_length = total_len_seen;
        length_total = length_total + {48'd0, total_len_seen};
      end
      if (tcp || udp) begin
        res.source_port = ports_seen[31:16];
        res.dest_port = ports_seen[15:0];
      end
      if (tcp) begin
        res.tcp_flag_bits = flags_seen;
        res.tcp_sequence = seq_ack_seen[63:32];
        res.tcp_acknowledge = seq_ack_seen[31:0];
      end
      res.packets_seen = frame_count;
      res.bytes_total = length_total;
      expected_results.push_back(res);
      byte_pos = '0;
      outer_etype = '0;
      inner_etype = '0;
      ihl_seen = '0;
      total_len_seen = '0;
      proto_seen = '0;
      src_seen = '0;
      dst_seen = '0;
      ports_seen = '0;
      seq_ack_seen = '0;
      flags_seen = '0;
    end
  endtask

  // one byte transaction; called and returning at a rising edge
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= last;
    do @(posedge clk); while (!in_ready);
    parse_byte(b, last);
  endtask

  task automatic send_frame();
    for (int k = 0; k < frame_buf.size(); k++) begin
      send_byte(frame_buf[k], k == frame_buf.size() - 1);
    end
  endtask

  // hold the sender off until every pending result has been seen
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  function automatic void put_byte(int idx, logic [7:0] v);
    if (idx < frame_buf.size()) frame_buf[idx] = v;
  endfunction

  // frame of n bytes, header fields placed where they fit, filler random or constant
  function automatic void make_frame(int n, bit vlan, logic [15:0] etype, logic [3:0] ihl,
                                     logic [7:0] proto, int fill = -1);
    int ip0;
    frame_buf.delete();
    for (int k = 0; k < n; k++) begin
      frame_buf.push_back(fill < 0 ? 8'($urandom_range(0, 255)) : 8'(fill));
    end
    ip0 = vlan ? ETH_LEN + TAG_LEN : ETH_LEN;
    put_byte(TYPE_HI, vlan ? TYPE_VLAN[15:8] : etype[15:8]);
    put_byte(TYPE_LO, vlan ? TYPE_VLAN[7:0] : etype[7:0]);
    if (vlan) begin
      put_byte(ITYPE_HI, etype[15:8]);
      put_byte(ITYPE_LO, etype[7:0]);
    end
    put_byte(ip0 + IP_VER_IHL, {4'h4, ihl});
    put_byte(ip0 + IP_PROTO, proto);
  endfunction

  // length that covers the ip header and the whole transport header
  function automatic int full_len(bit vlan, logic [3:0] ihl, logic [7:0] proto);
    int ip0;
    int tr_end;
    ip0 = vlan ? ETH_LEN + TAG_LEN : ETH_LEN;
    tr_end = ip0 + 4 * ihl + (proto == PROTO_TCP ? 20 : 8);
    return (tr_end > ip0 + IP_MIN_LEN) ? tr_end : ip0 + IP_MIN_LEN;
  endfunction

  task automatic compare_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      mismatch_count++;
    end
  endtask

  // receiver side: random stalls on out_ready
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else begin
      stall_left <= pick_gap();
      out_ready <= 1'b1;
    end
  end

  // result checker
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("result transaction with no frame pending");
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        compare_field("accepted", 64'(want.accepted), 64'(out_accepted));
        compare_field("protocol", 64'(want.protocol), 64'(out_protocol));
        compare_field("src_addr", 64'(want.src_addr), 64'(out_src_addr));
        compare_field("dst_addr", 64'(want.dst_addr), 64'(out_dst_addr));
        compare_field("source_port", 64'(want.source_port), 64'(out_source_port));
        compare_field("dest_port", 64'(want.dest_port), 64'(out_dest_port));
        compare_field("ip_total_length", 64'(want.ip_total_length),
                      64'(out_ip_total_length));
        compare_field("tcp_flag_bits", 64'(want.tcp_flag_bits), 64'(out_tcp_flag_bits));
        compare_field("tcp_sequence", 64'(want.tcp_sequence), 64'(out_tcp_sequence));
        compare_field("tcp_acknowledge", 64'(want.tcp_acknowledge),
                      64'(out_tcp_acknowledge));
        compare_field("packets_seen", want.packets_seen, out_packets_seen);
        compare_field("bytes_total", want.bytes_total, out_bytes_total);
      end
    end
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
        $display("status: fail");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic test_basic_protocols();
    make_frame(full_len(1'b0, 4'd5, PROTO_TCP), 1'b0, TYPE_IPV4, 4'd5, PROTO_TCP);
    send_frame();
    make_frame(full_len(1'b1, 4'd5, PROTO_UDP) + 6, 1'b1, TYPE_IPV4, 4'd5, PROTO_UDP);
    send_frame();
    make_frame(full_len(1'b0, 4'd7, PROTO_TCP), 1'b0, TYPE_IPV4, 4'd7, PROTO_TCP);
    send_frame();
    make_frame(40, 1'b0, TYPE_IPV4, 4'd5, 8'd1);
    send_frame();
  endtask

  task automatic test_rejected_types();
    make_frame(60, 1'b0, 16'h86dd, 4'd5, PROTO_TCP);
    send_frame();
    // second tag is not skipped
    make_frame(64, 1'b1, TYPE_VLAN, 4'd5, PROTO_UDP);
    send_frame();
  endtask

  task automatic test_short_frames();
    make_frame(1, 1'b0, TYPE_IPV4, 4'd5, PROTO_TCP);
    send_frame();
    make_frame(TYPE_LO, 1'b0, TYPE_IPV4, 4'd5, PROTO_TCP);
    send_frame();
    // one byte below and exactly at the minimum ip header, untagged and tagged
    make_frame(ETH_LEN + IP_MIN_LEN - 1, 1'b0, TYPE_IPV4, 4'd5, PROTO_TCP);
    send_frame();
    make_frame(ETH_LEN + IP_MIN_LEN, 1'b0, TYPE_IPV4, 4'd5, PROTO_TCP);
    send_frame();
    make_frame(ETH_LEN + TAG_LEN + IP_MIN_LEN - 1, 1'b1, TYPE_IPV4, 4'd5, PROTO_UDP);
    send_frame();
    make_frame(ETH_LEN + TAG_LEN + IP_MIN_LEN, 1'b1, TYPE_IPV4, 4'd5, PROTO_UDP);
    send_frame();
    // tcp cut in the middle of the sequence number
    make_frame(ETH_LEN + IP_MIN_LEN + 6, 1'b0, TYPE_IPV4, 4'd5, PROTO_TCP);
    send_frame();
  endtask

  task automatic test_small_ihl();
    for (int h = 0; h < 5; h++) begin
      make_frame(full_len(1'b0, 4'd5, PROTO_TCP), h[0], TYPE_IPV4, 4'(h), PROTO_TCP);
      send_frame();
    end
  endtask

  task automatic test_field_extremes();
    make_frame(full_len(1'b0, 4'd5, PROTO_TCP), 1'b0, TYPE_IPV4, 4'd0, 8'h00, 8'h00);
    send_frame();
    make_frame(full_len(1'b0, 4'd15, PROTO_TCP), 1'b0, TYPE_IPV4, 4'd15, 8'hff, 8'hff);
    send_frame();
    make_frame(full_len(1'b0, 4'd5, PROTO_TCP), 1'b0, TYPE_IPV4, 4'd5, PROTO_TCP, 8'hff);
    send_frame();
  endtask

  // frame running well past every capture point; the frame after it must start clean
  task automatic test_long_frame();
    idle_on = 1'b0;
    make_frame(128, 1'b0, TYPE_IPV4, 4'd5, PROTO_TCP);
    send_frame();
    make_frame(full_len(1'b1, 4'd5, PROTO_TCP), 1'b1, TYPE_IPV4, 4'd5, PROTO_TCP);
    send_frame();
    idle_on = 1'b1;
  endtask

  task automatic test_random_traffic();
    int sent_bytes;
    int frames;
    int kind;
    int n;
    bit vlan;
    logic [3:0] ihl;
    logic [7:0] proto;
    sent_bytes = 0;
    frames = 0;
    while (sent_bytes < 150) begin
      idle_on = ($urandom_range(0, 3) != 0);
      kind = $urandom_range(0, 99);
      vlan = ($urandom_range(0, 9) < 3);
      kind = $urandom_range(0, 99);
      proto = (kind % 4 == 0) ? 8'($urandom_range(0, 255)) :
              (kind % 4 == 1) ? PROTO_UDP : PROTO_TCP;
      if (kind < 75) begin
        ihl = ($urandom_range(0, 2) == 0) ? 4'($urandom_range(5, 15)) : 4'd5;
        n = full_len(vlan, ihl, proto) + $urandom_range(0, 16);
        if ($urandom_range(0, 9) == 0) n = $urandom_range(1, n);
        make_frame(n, vlan, TYPE_IPV4, ihl, proto);
      end else if (kind < 85) begin
        make_frame($urandom_range(1, 60), vlan, TYPE_IPV4, 4'($urandom_range(0, 4)), proto);
      end else if (kind < 93) begin
        make_frame($urandom_range(1, 70), vlan, 16'($urandom_range(0, 65535)), 4'd5, proto);
      end else begin
        make_frame($urandom_range(1, 70), 1'b1, TYPE_VLAN, 4'd5, proto);
      end
      send_frame();
      sent_bytes += frame_buf.size();
      frames++;
      if (frames % 3 == 0) drain_results();
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    idle_on = 1'b1;
    test_basic_protocols();
    test_rejected_types();
    test_short_frames();
    drain_results();
    test_small_ihl();
    test_field_extremes();
    test_long_frame();
    test_random_traffic();
    drain_results();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== ethernet_ipv4_five_tuple_parser_core.f =====
rtl/core/eip5t_pkg.sv
rtl/core/ethernet_ipv4_five_tuple_parser_core.sv
sim/ethernet_ipv4_five_tuple_parser_core_tb.sv
